[design/lva_pkg.sv]
`default_nettype none
package lva_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    // Stage indexes inside the normalization pipeline
    localparam int S_SUM     = 4;
    localparam int S_SQ_END  = S_SUM + SQRT_STEPS;
    localparam int S_DSET    = S_SQ_END + 1;
    localparam int S_DIV_END = S_DSET + DIV_STEPS;
    localparam int S_OUT     = S_DIV_END + 1;
    localparam int UNIT_LAT  = S_OUT + 1;

    localparam logic [31:0]        ONE_Q16  = 32'h0001_0000;
    localparam logic signed [63:0] ONE_Q30  = 64'sh4000_0000;
    localparam logic [1:0]         COL_LAST = 2'd3;

    typedef logic signed [31:0] v32_t [3];
    typedef logic signed [63:0] v64_t [3];
    typedef logic [31:0] mat_t [4][4];   // [column][row]

    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][31:0] aux;
    } side_t;

    function automatic logic [62:0] mag63(input logic signed [63:0] v);
        logic [63:0] a;
        a = v[63] ? 64'(-v) : 64'(v);
        return a[62:0];
    endfunction

    // Right shift needed so that every magnitude drops below 2^31
    function automatic logic [5:0] norm_shift(input logic [62:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 63; i++)
        begin
            if (v[i])
            begin
                n = 6'(i + 1);
            end
        end
        return (n > 6'd31) ? 6'(n - 6'd31) : 6'd0;
    endfunction

    // Round to nearest, ties away from zero
    function automatic logic signed [63:0] rshr64(input logic signed [63:0] v, input int sh);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? 64'(-v) : 64'(v);
        r = (m + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [63:0] v);
        if (v > ONE_Q30)
        begin
            return ONE_Q30[31:0];
        end
        if (v < -ONE_Q30)
        begin
            return 32'(-ONE_Q30);
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

[design/lva_unitize.sv]
`default_nettype none
module lva_unitize (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire lva_pkg::v64_t vin,
    input  wire lva_pkg::side_t in_side,
    output logic               out_valid,
    output lva_pkg::v32_t      qout,
    output lva_pkg::side_t     out_side
);

    localparam int UL = lva_pkg::UNIT_LAT;
    localparam int SS = lva_pkg::S_SUM;
    localparam int SD = lva_pkg::S_DSET;
    localparam int SE = lva_pkg::S_DIV_END;

    logic           vld_reg [UL];
    lva_pkg::side_t sb_reg  [UL];
    logic [2:0]     sgn_reg [UL];
    logic [62:0]    mag_reg [2][3];
    logic [5:0]     sh_reg;
    logic [30:0]    m_reg   [2:SD-1][3];
    logic [61:0]    sqr_reg [3];
    logic [63:0]    sx_reg  [SS:lva_pkg::S_SQ_END];
    logic [63:0]    sres_reg[SS:lva_pkg::S_SQ_END];
    logic           zf_reg  [SS:SE];
    logic [31:0]    dr_reg  [SD:SE][3];
    logic [30:0]    dn_reg  [SD:SE][3];
    logic [30:0]    dq_reg  [SD:SE][3];
    logic [31:0]    dd_reg  [SD:SE];
    logic signed [31:0] q_reg [3];

    logic [63:0] sx_next   [lva_pkg::SQRT_STEPS];
    logic [63:0] sres_next [lva_pkg::SQRT_STEPS];
    logic [31:0] dr_next   [lva_pkg::DIV_STEPS][3];
    logic        qb_next   [lva_pkg::DIV_STEPS][3];
    logic [61:0] num_next  [3];

    // One square-root digit per stage, one quotient bit per stage
    always_comb
    begin
        logic [63:0] bitv;
        logic [63:0] trial;
        logic [32:0] t;
        for (int k = 0; k < lva_pkg::SQRT_STEPS; k++)
        begin
            bitv  = 64'd1 << (62 - 2 * k);
            trial = sres_reg[SS + k] + bitv;
            if (sx_reg[SS + k] >= trial)
            begin
                sx_next[k]   = sx_reg[SS + k] - trial;
                sres_next[k] = (sres_reg[SS + k] >> 1) + bitv;
            end
            else
            begin
                sx_next[k]   = sx_reg[SS + k];
                sres_next[k] = sres_reg[SS + k] >> 1;
            end
        end
        for (int j = 0; j < lva_pkg::DIV_STEPS; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t = {dr_reg[SD + j][i], dn_reg[SD + j][i][30]};
                if (t >= {1'b0, dd_reg[SD + j]})
                begin
                    dr_next[j][i] = 32'(t - {1'b0, dd_reg[SD + j]});
                    qb_next[j][i] = 1'b1;
                end
                else
                begin
                    dr_next[j][i] = t[31:0];
                    qb_next[j][i] = 1'b0;
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = {1'b0, m_reg[SD - 1][i], 30'd0}
                        + 62'(sres_reg[lva_pkg::S_SQ_END][31:1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < UL; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < UL; s++)
            begin
                vld_reg[s] <= vld_reg[s - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= in_side;
            for (int i = 0; i < 3; i++)
            begin
                sgn_reg[0][i] <= vin[i][63];
                mag_reg[0][i] <= lva_pkg::mag63(vin[i]);
            end
            for (int s = 1; s < UL; s++)
            begin
                sb_reg[s]  <= sb_reg[s - 1];
                sgn_reg[s] <= sgn_reg[s - 1];
            end
            sh_reg <= lva_pkg::norm_shift(mag_reg[0][0] | mag_reg[0][1] | mag_reg[0][2]);
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[1][i] <= mag_reg[0][i];
                m_reg[2][i]   <= 31'(mag_reg[1][i] >> sh_reg);
                sqr_reg[i]    <= 62'(m_reg[2][i]) * 62'(m_reg[2][i]);
            end
            for (int s = 3; s < SD; s++)
            begin
                m_reg[s] <= m_reg[s - 1];
            end
            sx_reg[SS]   <= 64'(sqr_reg[0]) + 64'(sqr_reg[1]) + 64'(sqr_reg[2]);
            sres_reg[SS] <= 64'd0;
            zf_reg[SS]   <= ((sqr_reg[0] | sqr_reg[1] | sqr_reg[2]) == 62'd0);
            for (int k = 0; k < lva_pkg::SQRT_STEPS; k++)
            begin
                sx_reg[SS + k + 1]   <= sx_next[k];
                sres_reg[SS + k + 1] <= sres_next[k];
            end
            for (int s = SS + 1; s <= SE; s++)
            begin
                zf_reg[s] <= zf_reg[s - 1];
            end
            dd_reg[SD] <= sres_reg[lva_pkg::S_SQ_END][31:0];
            for (int i = 0; i < 3; i++)
            begin
                dr_reg[SD][i] <= 32'(num_next[i][61:31]);
                dn_reg[SD][i] <= num_next[i][30:0];
                dq_reg[SD][i] <= 31'd0;
            end
            for (int j = 0; j < lva_pkg::DIV_STEPS; j++)
            begin
                dd_reg[SD + j + 1] <= dd_reg[SD + j];
                for (int i = 0; i < 3; i++)
                begin
                    dr_reg[SD + j + 1][i] <= dr_next[j][i];
                    dn_reg[SD + j + 1][i] <= {dn_reg[SD + j][i][29:0], 1'b0};
                    dq_reg[SD + j + 1][i] <= {dq_reg[SD + j][i][29:0], qb_next[j][i]};
                end
            end
            // zero length: leave the vector at zero
            for (int i = 0; i < 3; i++)
            begin
                if (zf_reg[SE])
                begin
                    q_reg[i] <= 32'sd0;
                end
                else if (sgn_reg[SE][i])
                begin
                    q_reg[i] <= -$signed({1'b0, dq_reg[SE][i]});
                end
                else
                begin
                    q_reg[i] <= $signed({1'b0, dq_reg[SE][i]});
                end
            end
        end
    end

    assign out_valid = vld_reg[UL - 1];
    assign out_side  = sb_reg[UL - 1];
    assign qout      = q_reg;

endmodule
`default_nettype wire

[design/lva_cross.sv]
`default_nettype none
module lva_cross (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire lva_pkg::v32_t   f,
    input  wire lva_pkg::v32_t   up,
    input  wire logic [2:0][31:0] eye,
    output logic                 out_valid,
    output lva_pkg::v64_t        c,
    output lva_pkg::side_t       out_side
);

    logic               vld_reg [2];
    lva_pkg::side_t     sb_reg  [2];
    logic signed [63:0] p_reg   [6];
    logic signed [63:0] c_reg   [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vld_reg[1] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0].eye <= eye;
            for (int i = 0; i < 3; i++)
            begin
                sb_reg[0].aux[i] <= f[i];
            end
            sb_reg[1] <= sb_reg[0];
            p_reg[0] <= f[1] * up[2];
            p_reg[1] <= f[2] * up[1];
            p_reg[2] <= f[2] * up[0];
            p_reg[3] <= f[0] * up[2];
            p_reg[4] <= f[0] * up[1];
            p_reg[5] <= f[1] * up[0];
            c_reg[0] <= p_reg[0] - p_reg[1];
            c_reg[1] <= p_reg[2] - p_reg[3];
            c_reg[2] <= p_reg[4] - p_reg[5];
        end
    end

    assign out_valid = vld_reg[1];
    assign out_side  = sb_reg[1];
    assign c         = c_reg;

endmodule
`default_nettype wire

[design/lva_finish.sv]
`default_nettype none
module lva_finish (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire lva_pkg::v32_t   s,
    input  wire logic [2:0][31:0] f,
    input  wire logic [2:0][31:0] eye,
    output logic                 out_valid,
    output lva_pkg::mat_t        cols
);

    logic               vld_reg [1:7];
    logic signed [31:0] s_reg   [1:4][3];
    logic signed [31:0] f_reg   [1:4][3];
    logic signed [31:0] e_reg   [1:4][3];
    logic signed [63:0] psf_reg [6];
    logic signed [63:0] ud_reg  [3];
    logic signed [31:0] u_reg   [3];
    logic signed [63:0] pse_reg [3];
    logic signed [63:0] pue_reg [3];
    logic signed [63:0] pfe_reg [3];
    logic signed [31:0] es_reg  [4:5][3];
    logic signed [31:0] eu_reg  [4:5][3];
    logic signed [31:0] ef_reg  [4:5][3];
    logic signed [63:0] ds_reg, du_reg, df_reg;
    logic [31:0]        col_reg [4][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 7; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int k = 2; k <= 7; k++)
            begin
                vld_reg[k] <= vld_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s_reg[1][i] <= s[i];
                f_reg[1][i] <= $signed(f[i]);
                e_reg[1][i] <= $signed(eye[i]);
            end
            for (int k = 2; k <= 4; k++)
            begin
                s_reg[k] <= s_reg[k - 1];
                f_reg[k] <= f_reg[k - 1];
                e_reg[k] <= e_reg[k - 1];
            end
            // true up = side x forward
            psf_reg[0] <= s_reg[1][1] * f_reg[1][2];
            psf_reg[1] <= s_reg[1][2] * f_reg[1][1];
            psf_reg[2] <= s_reg[1][2] * f_reg[1][0];
            psf_reg[3] <= s_reg[1][0] * f_reg[1][2];
            psf_reg[4] <= s_reg[1][0] * f_reg[1][1];
            psf_reg[5] <= s_reg[1][1] * f_reg[1][0];
            ud_reg[0] <= psf_reg[0] - psf_reg[1];
            ud_reg[1] <= psf_reg[2] - psf_reg[3];
            ud_reg[2] <= psf_reg[4] - psf_reg[5];
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i]     <= lva_pkg::clamp_q30(lva_pkg::rshr64(ud_reg[i], 30));
                pse_reg[i]   <= s_reg[4][i] * e_reg[4][i];
                pue_reg[i]   <= u_reg[i] * e_reg[4][i];
                pfe_reg[i]   <= f_reg[4][i] * e_reg[4][i];
                es_reg[4][i] <= 32'(lva_pkg::rshr64(64'(s_reg[4][i]), 14));
                eu_reg[4][i] <= 32'(lva_pkg::rshr64(64'(u_reg[i]), 14));
                ef_reg[4][i] <= 32'(-lva_pkg::rshr64(64'(f_reg[4][i]), 14));
            end
            es_reg[5] <= es_reg[4];
            eu_reg[5] <= eu_reg[4];
            ef_reg[5] <= ef_reg[4];
            ds_reg <= pse_reg[0] + pse_reg[1] + pse_reg[2];
            du_reg <= pue_reg[0] + pue_reg[1] + pue_reg[2];
            df_reg <= pfe_reg[0] + pfe_reg[1] + pfe_reg[2];
            for (int k = 0; k < 3; k++)
            begin
                col_reg[k][0] <= es_reg[5][k];
                col_reg[k][1] <= eu_reg[5][k];
                col_reg[k][2] <= ef_reg[5][k];
                col_reg[k][3] <= 32'd0;
            end
            col_reg[3][0] <= lva_pkg::sat32(lva_pkg::rshr64(-ds_reg, 30));
            col_reg[3][1] <= lva_pkg::sat32(lva_pkg::rshr64(-du_reg, 30));
            col_reg[3][2] <= lva_pkg::sat32(lva_pkg::rshr64(df_reg, 30));
            col_reg[3][3] <= lva_pkg::ONE_Q16;
        end
    end

    assign out_valid = vld_reg[7];
    assign cols      = col_reg;

endmodule
`default_nettype wire

[design/lva_colout.sv]
`default_nettype none
module lva_colout (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire lva_pkg::mat_t in_cols,
    output logic               en,
    input  wire logic          tready,
    output logic               tvalid,
    output logic [127:0]       tdata,
    output logic [1:0]         tuser,
    output logic               tlast
);

    lva_pkg::mat_t buf_reg;
    logic          full_reg;
    logic [1:0]    col_reg;

    // Advance the pipeline when the buffer is empty or its last column leaves
    assign en = !full_reg || (tready && (col_reg == lva_pkg::COL_LAST));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            col_reg  <= 2'd0;
        end
        else if (en)
        begin
            full_reg <= in_valid;
            col_reg  <= 2'd0;
        end
        else if (tready)
        begin
            col_reg <= col_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            buf_reg <= in_cols;
        end
    end

    assign tvalid = full_reg;
    assign tuser  = col_reg;
    assign tlast  = (col_reg == lva_pkg::COL_LAST);
    assign tdata  = {buf_reg[col_reg][3], buf_reg[col_reg][2],
                     buf_reg[col_reg][1], buf_reg[col_reg][0]};

endmodule
`default_nettype wire

[design/lookat_view_matrix_top.sv]
// Look-at view matrix: one request carries eye, target and up vectors (signed Q16.16)
// and yields the column-major 4x4 view matrix as four column beats, column 0 first,
// tuser giving the column and tlast set on column 3. A request reaches the first column
// through two 70-stage normalization pipelines with their square-root and divider
// stages, plus cross-product and dot-product stages. New requests are taken while
// earlier ones are in flight; the column port sends one column per cycle while tready
// is high, and the whole pipeline holds while a finished matrix is still being sent.
`default_nettype none
module lookat_view_matrix_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
    input  wire logic [287:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // elem_row0, elem_row1, elem_row2, elem_row3
    output logic [127:0]      m_axis_tdata,
    // column_index
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    logic en;
    logic vld0_reg;
    logic signed [31:0] eye0_reg [3];
    logic signed [31:0] up0_reg  [3];
    lva_pkg::v64_t      d0;
    logic signed [63:0] d0_reg   [3];
    lva_pkg::side_t     side0;

    logic               a_valid;
    lva_pkg::v32_t      a_q;
    lva_pkg::side_t     a_side;
    lva_pkg::v32_t      a_up;

    logic               x_valid;
    lva_pkg::v64_t      x_c;
    lva_pkg::side_t     x_side;

    logic               b_valid;
    lva_pkg::v32_t      b_q;
    lva_pkg::side_t     b_side;

    logic               m_valid;
    lva_pkg::mat_t      m_cols;

    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                eye0_reg[i] <= $signed(s_axis_tdata[32 * i +: 32]);
                up0_reg[i]  <= $signed(s_axis_tdata[192 + 32 * i +: 32]);
                d0_reg[i]   <= 64'($signed(s_axis_tdata[96 + 32 * i +: 32]))
                             - 64'($signed(s_axis_tdata[32 * i +: 32]));
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d0[i]        = d0_reg[i];
            side0.eye[i] = eye0_reg[i];
            side0.aux[i] = up0_reg[i];
            a_up[i]      = $signed(a_side.aux[i]);
        end
    end

    lva_unitize u_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (vld0_reg),
        .vin      (d0),
        .in_side  (side0),
        .out_valid(a_valid),
        .qout     (a_q),
        .out_side (a_side)
    );

    lva_cross u_cross (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (a_valid),
        .f        (a_q),
        .up       (a_up),
        .eye      (a_side.eye),
        .out_valid(x_valid),
        .c        (x_c),
        .out_side (x_side)
    );

    lva_unitize u_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (x_valid),
        .vin      (x_c),
        .in_side  (x_side),
        .out_valid(b_valid),
        .qout     (b_q),
        .out_side (b_side)
    );

    lva_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (b_valid),
        .s        (b_q),
        .f        (b_side.aux),
        .eye      (b_side.eye),
        .out_valid(m_valid),
        .cols     (m_cols)
    );

    lva_colout u_colout (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(m_valid),
        .in_cols (m_cols),
        .en      (en),
        .tready  (m_axis_tready),
        .tvalid  (m_axis_tvalid),
        .tdata   (m_axis_tdata),
        .tuser   (m_axis_tuser),
        .tlast   (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 2'd1)))
        else $error("column sequence broken");
    a_col_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
        (!m_axis_tvalid || (m_axis_tuser == 2'd0)))
        else $error("matrix does not start at column 0");
    a_row3: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
        (m_axis_tdata[127:96] == (m_axis_tlast ? lva_pkg::ONE_Q16 : 32'd0)))
        else $error("bad row 3 element");
`endif

endmodule
`default_nettype wire
